/* src/mbm_pkg.sv */
package mbm_pkg;

	typedef enum logic [2:0] {
		CMD_MAP_WR = 3'd0,
		CMD_PRG    = 3'd1,
		CMD_CHR    = 3'd2,
		CMD_NT_RD  = 3'd3,
		CMD_NT_WR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MIR_HORZ = 2'd0,
		MIR_VERT = 2'd1,
		MIR_FOUR = 2'd2
	} mirror_t;

	localparam logic [5:0] CHR_BANK_RST = 6'd0;
	localparam logic [4:0] ROM_PAGE_RST = 5'd31;

	// nametable window upper bound page (0x3f00 and up is out)
	localparam logic [4:0] NT_TOP_PAGE = 5'h1f;

	typedef struct packed {
		logic we;
		logic re;
	} nt_ctl_t;

endpackage

/* src/mbm_nt_ram.sv */
module mbm_nt_ram #(
	parameter int NT_RAM_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbm_pkg::nt_ctl_t                ctl,
	input  logic [$clog2(NT_RAM_BYTES)-1:0] idx,
	input  logic [7:0]                      wdata,
	output logic [7:0]                      rdata,
	output logic                            busy
);

	localparam int AW = $clog2(NT_RAM_BYTES);
	localparam logic [AW-1:0] LAST = AW'(NT_RAM_BYTES - 1);

	logic [7:0]    mem [NT_RAM_BYTES];
	logic [AW-1:0] clr_q;
	logic          busy_q;
	logic [7:0]    rdata_q;

	// clearing sweep, one byte per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 8'd0;
		end else if (ctl.we) begin
			mem[idx] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[idx];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

/* src/mbm_xlate.sv */
module mbm_xlate #(
	parameter int NT_RAM_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  logic [2:0]                      cmd,
	input  logic [15:0]                     bus_addr,
	output logic [19:0]                     rom_addr,
	output logic                            addr_error,
	output logic                            nt_read,
	output mbm_pkg::nt_ctl_t                nt_ctl,
	output logic [$clog2(NT_RAM_BYTES)-1:0] nt_idx
);

	localparam int AW = $clog2(NT_RAM_BYTES);
	localparam logic [12:0] NT_SIZE = 13'(NT_RAM_BYTES);

	logic [5:0]       chr_bank_q;
	logic [4:0]       rom_page_q;
	logic             prg_upper_q;
	logic             prg_small_q;
	mbm_pkg::mirror_t mirror_q;

	logic        nt_in_win;
	logic        page_hi;
	logic        page_lo;
	logic [12:0] idx_raw;
	logic [12:0] idx_mod;
	logic        map_load;

	assign nt_in_win = (bus_addr[15:13] == 3'b001) && (bus_addr[12:8] != mbm_pkg::NT_TOP_PAGE);
	assign map_load  = fire && (cmd == mbm_pkg::CMD_MAP_WR) && bus_addr[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_bank_q  <= mbm_pkg::CHR_BANK_RST;
			rom_page_q  <= mbm_pkg::ROM_PAGE_RST;
			prg_upper_q <= 1'b0;
			prg_small_q <= 1'b1;
			mirror_q    <= mbm_pkg::MIR_FOUR;
		end else if (map_load) begin
			chr_bank_q  <= bus_addr[5:0];
			prg_upper_q <= bus_addr[6];
			rom_page_q  <= bus_addr[11:7];
			prg_small_q <= bus_addr[12];
			mirror_q    <= bus_addr[13] ? mbm_pkg::MIR_HORZ : mbm_pkg::MIR_VERT;
		end
	end

	// quadrant to page through the mirroring map
	always_comb begin
		unique case (mirror_q)
			mbm_pkg::MIR_HORZ: begin
				page_hi = 1'b0;
				page_lo = bus_addr[11];
			end
			mbm_pkg::MIR_VERT: begin
				page_hi = 1'b0;
				page_lo = bus_addr[10];
			end
			default: begin
				page_hi = bus_addr[11];
				page_lo = bus_addr[10];
			end
		endcase
	end

	// index stays below twice the ram size, one subtract wraps it
	assign idx_raw = {1'b0, page_hi, page_lo, bus_addr[9:0]};
	assign idx_mod = (idx_raw >= NT_SIZE) ? (idx_raw - NT_SIZE) : idx_raw;
	assign nt_idx  = idx_mod[AW-1:0];

	always_comb begin
		rom_addr   = '0;
		addr_error = 1'b0;
		nt_read    = 1'b0;
		nt_ctl     = '0;
		unique case (cmd)
			mbm_pkg::CMD_MAP_WR: begin
				addr_error = !bus_addr[15];
			end
			mbm_pkg::CMD_PRG: begin
				addr_error = !bus_addr[15];
				if (bus_addr[15]) begin
					rom_addr = prg_small_q ? {rom_page_q, prg_upper_q, bus_addr[13:0]}
						: {rom_page_q, bus_addr[14:0]};
				end
			end
			mbm_pkg::CMD_CHR: begin
				addr_error = (bus_addr[15:13] != 3'b000);
				if (bus_addr[15:13] == 3'b000) begin
					rom_addr = {1'b0, chr_bank_q, bus_addr[12:0]};
				end
			end
			mbm_pkg::CMD_NT_RD: begin
				addr_error = !nt_in_win;
				nt_read    = nt_in_win;
				nt_ctl.re  = fire && nt_in_win;
			end
			mbm_pkg::CMD_NT_WR: begin
				addr_error = !nt_in_win;
				nt_ctl.we  = fire && nt_in_win;
			end
			default: begin
				addr_error = 1'b1;
			end
		endcase
	end

endmodule

/* src/multicart_bank_mapper_with_nametable_unit.sv */
// pipeline: an input transfer is registered in stage s1, moves into stage s2 once s2
// is empty or leaving, and its result is shown from s2; a result stall holds it in s1
// throughput: one access per cycle, as long as the result side keeps up and the ram clear is done
// reset: chr bank 0, prg bank 31, lower half, 16K mode, four-screen mirroring
// after reset the nametable ram is zeroed by a sweep over all NT_RAM_BYTES bytes,
// in_stall stays high until the sweep ends
module multicart_bank_mapper_with_nametable_unit #(
	parameter int NT_RAM_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [15:0] bus_addr,
	input  logic [7:0]  wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] rom_addr,
	output logic [7:0]  rd_data,
	output logic        addr_error
);

	localparam int AW = $clog2(NT_RAM_BYTES);

	logic        vld_s1;
	logic [2:0]  cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;

	logic        vld_s2;
	logic [19:0] rom_addr_s2;
	logic        err_s2;
	logic        rd_s2;

	logic             fire;
	logic             ram_busy;
	logic [19:0]      x_rom_addr;
	logic             x_err;
	logic             x_nt_read;
	mbm_pkg::nt_ctl_t nt_ctl;
	logic [AW-1:0]    nt_idx;
	logic [7:0]       ram_rdata;

	assign fire     = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = ram_busy || (vld_s1 && !fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= cmd;
			addr_s1  <= bus_addr;
			wdata_s1 <= wr_data;
		end
	end

	mbm_xlate #(
		.NT_RAM_BYTES(NT_RAM_BYTES)
	) u_xlate (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cmd       (cmd_s1),
		.bus_addr  (addr_s1),
		.rom_addr  (x_rom_addr),
		.addr_error(x_err),
		.nt_read   (x_nt_read),
		.nt_ctl    (nt_ctl),
		.nt_idx    (nt_idx)
	);

	mbm_nt_ram #(
		.NT_RAM_BYTES(NT_RAM_BYTES)
	) u_nt_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (nt_ctl),
		.idx   (nt_idx),
		.wdata (wdata_s1),
		.rdata (ram_rdata),
		.busy  (ram_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rom_addr_s2 <= x_rom_addr;
			err_s2      <= x_err;
			rd_s2       <= x_nt_read;
		end
	end

	// ram read data is registered in the ram and only moves on a transfer
	assign out_valid  = vld_s2;
	assign rom_addr   = rom_addr_s2;
	assign addr_error = err_s2;
	assign rd_data    = rd_s2 ? ram_rdata : 8'd0;

endmodule
